// ===== design/assert_macros.svh =====
// Assertion macros shared by the timer list RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== design/swtl_pkg.sv =====
// Types and codes for the software timer list.
// Used by the output stage and the top level; depends on nothing.
`default_nettype none

package swtl_pkg;

   localparam int RSP_DATA_W = 40;
   localparam int REQ_DATA_W = 136;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] interval;
      logic [63:0] start;
      logic        one_shot;
   } entry_type;

   typedef struct packed {
      logic [31:0] timer_id;
      logic        fired;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

endpackage

`default_nettype wire

// ===== design/software_timer_list.sv =====
// Top level of the software timer list: entry memory, scan sequencer and counters.
// Depends on swtl_pkg, swtl_out_stage and assert_macros.svh.
//
//   channel   direction   payload
//   req_*     in          tuser: operation; tdata: now_time, interval, one_shot, target_id
//   rsp_*     out         tdata: timer_id, fired, status; tlast: last
//
// Create passes its result word through the final register into the output register once it is free.
// Cancel and tick walk the entry memory through its one read port, one entry per cycle
// while the walk is not stalled.
// A tick stalls its walk while a fired word waits for an occupied output register.
// Reset is synchronous; it empties the list and sets the next id to one.
`default_nettype none
`include "assert_macros.svh"

module software_timer_list
   import swtl_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // now_time [63:0], interval [95:64], one_shot [96], target_id [128:97], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // timer_id [31:0], fired [32], status [34:33], zero fill [39:35]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   entry_type entry_mem [SLOTS];
   entry_type rd_data_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   next_id_ff, next_id_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          proc_valid_ff, proc_valid_in;
   logic          found_ff, found_in;
   logic          hold_valid_ff, hold_valid_in;
   logic [31:0]   hold_id_ff, hold_id_in;
   logic [1:0]    op_ff, op_in;
   logic [63:0]   now_ff, now_in;
   logic [31:0]   target_ff, target_in;
   result_type    final_ff, final_in;

   logic          req_accept;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          issue;
   logic          hit;
   logic          expired;
   logic          stall;
   logic [64:0]   due_time;
   logic          out_free;
   push_type      push;
   entry_type     kept;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Expiry is start + interval <= now at full width, so a late start never fires.
   assign due_time = {1'b0, rd_data_ff.start} + {33'b0, rd_data_ff.interval};
   assign issue    = (rd_ptr_ff < count_ff);
   assign hit      = proc_valid_ff && (op_ff == OP_CANCEL) && !found_ff
                     && (rd_data_ff.id == target_ff);
   assign expired  = proc_valid_ff && (op_ff == OP_TICK) && (due_time <= {1'b0, now_ff});
   assign stall    = expired && hold_valid_ff && !out_free;

   always_comb begin
      kept = rd_data_ff;
      if (expired) begin
         kept.start = now_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      proc_valid_in = proc_valid_ff;
      found_in      = found_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      target_in     = target_ff;
      final_in      = final_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      push          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_tuser;
               now_in        = req_tdata[63:0];
               target_in     = req_tdata[128:97];
               rd_ptr_in     = '0;
               wr_ptr_in     = '0;
               proc_valid_in = 1'b0;
               found_in      = 1'b0;
               hold_valid_in = 1'b0;
               if (req_tuser == OP_CREATE) begin
                  if (count_ff < CW'(SLOTS)) begin
                     mem_we     = 1'b1;
                     mem_waddr  = count_ff[AW-1:0];
                     mem_wdata  = '{id: next_id_ff, interval: req_tdata[95:64],
                                    start: req_tdata[63:0], one_shot: req_tdata[96]};
                     count_in   = count_ff + 1'b1;
                     next_id_in = next_id_ff + 32'd1;
                     final_in   = '{timer_id: next_id_ff, fired: 1'b0,
                                    status: STATUS_OK, last: 1'b1};
                  end else begin
                     final_in   = '{timer_id: 32'd0, fired: 1'b0,
                                    status: STATUS_FULL, last: 1'b1};
                  end
                  state_in = S_FINISH;
               end else if (req_tuser == OP_CANCEL || req_tuser == OP_TICK) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!stall) begin
               if (proc_valid_ff) begin
                  // Survivors are packed down to the write pointer, which never
                  // passes the read pointer, so no unread entry is overwritten.
                  if (hit) begin
                     found_in = 1'b1;
                  end else if (!(expired && rd_data_ff.one_shot)) begin
                     mem_we    = 1'b1;
                     mem_waddr = wr_ptr_ff[AW-1:0];
                     mem_wdata = kept;
                     wr_ptr_in = wr_ptr_ff + 1'b1;
                  end
                  if (expired) begin
                     // The newest fired id is held back until we know whether it is last.
                     if (hold_valid_ff) begin
                        push.valid  = 1'b1;
                        push.result = '{timer_id: hold_id_ff, fired: 1'b1,
                                        status: STATUS_OK, last: 1'b0};
                     end
                     hold_valid_in = 1'b1;
                     hold_id_in    = rd_data_ff.id;
                  end
               end
               proc_valid_in = issue;
               if (issue) begin
                  mem_re    = 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
               if (!proc_valid_ff && !issue) begin
                  count_in = wr_ptr_ff;
                  if (op_ff == OP_CANCEL) begin
                     final_in = '{timer_id: target_ff, fired: 1'b0,
                                  status: found_ff ? STATUS_OK : STATUS_NONE, last: 1'b1};
                  end else if (hold_valid_ff) begin
                     final_in = '{timer_id: hold_id_ff, fired: 1'b1,
                                  status: STATUS_OK, last: 1'b1};
                  end else begin
                     final_in = '{timer_id: 32'd0, fired: 1'b0,
                                  status: STATUS_OK, last: 1'b1};
                  end
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               push.valid  = 1'b1;
               push.result = final_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_id_ff    <= 32'd1;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         proc_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         proc_valid_ff <= proc_valid_in;
         found_ff      <= found_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_id_ff <= hold_id_in;
      op_ff      <= op_in;
      now_ff     <= now_in;
      target_ff  <= target_in;
      final_ff   <= final_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[rd_ptr_ff[AW-1:0]];
      end
   end

   swtl_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_CLK(a_count_range, count_ff <= CW'(SLOTS), "entry count beyond capacity")
   `ASSERT_CLK(a_pack_order, (state_ff == S_SCAN) |-> (wr_ptr_ff <= rd_ptr_ff), "write passed read")
   `ASSERT_CLK(a_scan_op, (state_ff == S_SCAN) |-> (op_ff == OP_CANCEL || op_ff == OP_TICK), "bad scan op")
   `ASSERT_CLK(a_id_step, (req_accept && req_tuser == OP_CREATE && count_ff < CW'(SLOTS)) |=> (next_id_ff == $past(next_id_ff) + 32'd1), "id not advanced")

endmodule

`default_nettype wire

// ===== design/swtl_out_stage.sv =====
// Output register of the timer list: holds one result word until it is taken.
// Depends on swtl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module swtl_out_stage
   import swtl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire push_type              push,
   output logic                       out_free,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // timer_id [31:0], fired [32], status [34:33], zero fill [39:35]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         result_ff <= push.result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 35){1'b0}}, result_ff.status, result_ff.fired,
                        result_ff.timer_id};
   assign rsp_tlast  = result_ff.last;

   // A new word may only land when the register is empty or being drained.
   `ASSERT_NEVER(a_push_overrun, push.valid && valid_ff && !rsp_tready, "push into full stage")

endmodule

`default_nettype wire
